// ----- rtl/mts_pkg.sv -----
// Package for the Mobius table sieve: shared constants, codes and the table entry type.
// Used by mts_mem, mts_ctrl and mobius_table_sieve_top; depends on nothing.
package mts_pkg;

    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int SIEVE_BOUND_W     = 11;
    localparam int SIEVE_BOUND_RESET = 1024;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic FUNC_BUILD  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic CFG_IDX_SIEVE_BOUND = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DONE = 2'd1,
        STATUS_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic              mark;
        logic signed [1:0] mu;
    } mts_entry_t;

endpackage

// ----- rtl/mobius_table_sieve_top.sv -----
// Top level of the Mobius table sieve: APB register, sequencer and table memory.
// Instantiates mts_ctrl and mts_mem; uses mts_pkg.
//
//  Channel   Handshake                        Word
//  -------   ------------------------------   --------------------------
//  command   start && !busy                   func, query_index
//  result    result_strobe (one cycle)        status, mobius_value
//  config    psel && penable && pwrite        sieve_bound at paddr 0
//
// A lookup whose index is good reads the table, holds busy while in ST_LOOK and returns
// the entry read; a flagged lookup returns its error word straight from idle and never sets busy.
// A build of bound B fills each entry up to B, then reads the mark of each candidate p up to B
// and, for each p left unmarked, walks and writes every multiple of p up to B.
// Reset clears the sequencer and the built flag; the table is filled by each build.
// Results cannot be stalled.
module mobius_table_sieve_top
    import mts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic [SIEVE_BOUND_W-1:0] query_index,
    output logic                     result_strobe,
    output logic [1:0]               status,
    output logic signed [1:0]        mobius_value
);

    localparam int BOUND_MAX = (1 << SIEVE_BOUND_W) - 1;
    localparam int MEM_LAST  = (TABLE_DEPTH < BOUND_MAX) ? TABLE_DEPTH : BOUND_MAX;
    localparam int ADDR_W    = $clog2(MEM_LAST + 1);

    logic [SIEVE_BOUND_W-1:0] sieve_bound_reg;
    logic                     cfg_write;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    mts_entry_t               mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    mts_entry_t               mem_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sieve_bound_reg <= SIEVE_BOUND_W'(SIEVE_BOUND_RESET);
        end
        else if (cfg_write && (paddr[2] == CFG_IDX_SIEVE_BOUND))
        begin
            sieve_bound_reg <= pwdata[SIEVE_BOUND_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_SIEVE_BOUND) ? APB_DATA_W'(sieve_bound_reg) : '0;

    mts_ctrl #(
        .MEM_LAST (MEM_LAST),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .query_index   (query_index),
        .sieve_bound   (sieve_bound_reg),
        .busy          (busy),
        .result_strobe (result_strobe),
        .status        (status),
        .mobius_value  (mobius_value),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    mts_mem #(
        .DEPTH  (MEM_LAST + 1),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- rtl/mts_mem.sv -----
// Table memory holding one sieve mark and one Mobius value per index.
// One write port, one registered read port with write-to-read forwarding; uses mts_pkg.
module mts_mem
    import mts_pkg::*;
#(
    parameter int DEPTH  = TABLE_DEPTH_DEF + 1,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  mts_entry_t        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output mts_entry_t        rdata
);

    mts_entry_t mem_array [DEPTH];
    mts_entry_t rd_reg;
    mts_entry_t fwd_data_reg;
    logic       fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rd_reg       <= mem_array[raddr];
        fwd_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = fwd_hit_reg ? fwd_data_reg : rd_reg;

endmodule

// ----- rtl/mts_ctrl.sv -----
// Sequencer for the Mobius table sieve: build sweep, sieve walks and lookups.
// Drives the mts_mem ports and the result registers; uses mts_pkg.
module mts_ctrl
    import mts_pkg::*;
#(
    parameter int MEM_LAST = TABLE_DEPTH_DEF,
    parameter int ADDR_W   = $clog2(MEM_LAST + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     func,
    input  logic [SIEVE_BOUND_W-1:0] query_index,
    input  logic [SIEVE_BOUND_W-1:0] sieve_bound,
    output logic                     busy,
    output logic                     result_strobe,
    output logic [1:0]               status,
    output logic signed [1:0]        mobius_value,
    output logic                     mem_we,
    output logic [ADDR_W-1:0]        mem_waddr,
    output mts_entry_t               mem_wdata,
    output logic [ADDR_W-1:0]        mem_raddr,
    input  mts_entry_t               mem_rdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_INIT = 6'b000010,
        ST_PCHK = 6'b000100,
        ST_PDEC = 6'b001000,
        ST_WALK = 6'b010000,
        ST_LOOK = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] bound_reg, bound_next;
    logic [ADDR_W:0]   p_reg, p_next;
    logic [ADDR_W:0]   n_reg, n_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_zero_reg, pend_zero_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              built_reg, built_next;
    logic [ADDR_W-1:0] built_bound_reg, built_bound_next;
    logic              strobe_reg, strobe_next;
    status_t           status_reg, status_next;
    logic signed [1:0] value_reg, value_next;

    logic                     accept;
    logic                     idx_bad;
    logic [SIEVE_BOUND_W-1:0] bound_sat;
    logic                     k_wrap;

    assign accept    = start && (state_reg == ST_IDLE);
    assign idx_bad   = !built_reg || (query_index == '0)
                       || (query_index > SIEVE_BOUND_W'(built_bound_reg));
    assign bound_sat = (sieve_bound > SIEVE_BOUND_W'(MEM_LAST))
                       ? SIEVE_BOUND_W'(MEM_LAST) : sieve_bound;
    assign k_wrap    = ({1'b0, k_reg} == p_reg);

    always_comb
    begin
        state_next       = state_reg;
        bound_next       = bound_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        k_next           = k_reg;
        pend_valid_next  = 1'b0;
        pend_zero_next   = pend_zero_reg;
        pend_addr_next   = pend_addr_reg;
        built_next       = built_reg;
        built_bound_next = built_bound_reg;
        strobe_next      = 1'b0;
        status_next      = status_reg;
        value_next       = value_reg;
        mem_raddr        = query_index[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_BUILD)
                    begin
                        bound_next = bound_sat[ADDR_W-1:0];
                        if (bound_sat == '0)
                        begin
                            strobe_next      = 1'b1;
                            status_next      = STATUS_DONE;
                            value_next       = 2'sb00;
                            built_next       = 1'b1;
                            built_bound_next = '0;
                        end
                        else
                        begin
                            n_next     = (ADDR_W+1)'(1);
                            state_next = ST_INIT;
                        end
                    end
                    else if (idx_bad)
                    begin
                        strobe_next = 1'b1;
                        status_next = STATUS_ERR;
                        value_next  = 2'sb00;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_INIT:
            begin
                if (n_reg == {1'b0, bound_reg})
                begin
                    p_next     = (ADDR_W+1)'(2);
                    state_next = ST_PCHK;
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                end
            end
            ST_PCHK:
            begin
                if (p_reg > {1'b0, bound_reg})
                begin
                    strobe_next      = 1'b1;
                    status_next      = STATUS_DONE;
                    value_next       = 2'sb00;
                    built_next       = 1'b1;
                    built_bound_next = bound_reg;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    mem_raddr  = p_reg[ADDR_W-1:0];
                    state_next = ST_PDEC;
                end
            end
            ST_PDEC:
            begin
                if (mem_rdata.mark)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = ST_PCHK;
                end
                else
                begin
                    n_next     = p_reg;
                    k_next     = ADDR_W'(1);
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (n_reg <= {1'b0, bound_reg})
                begin
                    mem_raddr       = n_reg[ADDR_W-1:0];
                    pend_valid_next = 1'b1;
                    pend_addr_next  = n_reg[ADDR_W-1:0];
                    pend_zero_next  = k_wrap;
                    n_next          = n_reg + p_reg;
                    k_next          = k_wrap ? ADDR_W'(1) : k_reg + 1'b1;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = ST_PCHK;
                end
            end
            ST_LOOK:
            begin
                strobe_next = 1'b1;
                status_next = STATUS_OK;
                value_next  = mem_rdata.mu;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = n_reg[ADDR_W-1:0];
        mem_wdata = '{mark: 1'b0, mu: 2'sb01};
        if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = '{mark: 1'b1, mu: pend_zero_reg ? 2'sb00 : -mem_rdata.mu};
        end
        else if (state_reg == ST_INIT)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pend_valid_reg  <= 1'b0;
            built_reg       <= 1'b0;
            built_bound_reg <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_valid_reg  <= pend_valid_next;
            built_reg       <= built_next;
            built_bound_reg <= built_bound_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg     <= bound_next;
        p_reg         <= p_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        pend_zero_reg <= pend_zero_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        value_reg     <= value_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign mobius_value  = value_reg;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr != '0) && (mem_waddr <= bound_reg))
        else $error("Table write outside the active bound.");

    a_init_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> !pend_valid_reg)
        else $error("Sieve write pending during the initial sweep.");

    a_done_sets_built: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (status_reg == STATUS_DONE)) |-> built_reg && (value_reg == 2'sb00))
        else $error("Build reported done without the table marked built.");

    a_lookup_value_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (status_reg == STATUS_OK)) |-> (value_reg != 2'sb10))
        else $error("Lookup returned an illegal Mobius value.");

    a_pend_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> $past(state_reg == ST_WALK))
        else $error("Sieve write without a walk read one cycle earlier.");

endmodule

// ----- sim/mobius_table_sieve_top_tb.sv -----
// Testbench for mobius_table_sieve_top: directed and random build and lookup words,
// each result checked against a sieve of the Mobius function kept in the bench.
// Depends on mts_pkg and the RTL of mobius_table_sieve_top.
module mobius_table_sieve_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int RANDOM_WORDS = 1850;

    typedef struct {
        logic                     f;
        logic [SIEVE_BOUND_W-1:0] idx;
    } sieve_cmd_t;

    typedef struct {
        status_t           st;
        logic signed [1:0] mu;
    } mu_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     func = FUNC_BUILD;
    logic [SIEVE_BOUND_W-1:0] query_index = '0;
    logic                     result_strobe;
    logic [1:0]               status;
    logic signed [1:0]        mobius_value;

    sieve_cmd_t cmd_q[$];
    mu_word_t   awaited_words[$];
    logic       word_taken = 1'b0;
    int         sender_idle_pct = 0;
    int         items_sent = 0;
    int         fault_count = 0;

    logic signed [1:0]        mu_mirror [0:DEPTH];
    logic                     sieve_marks [0:DEPTH];
    logic                     table_ready = 1'b0;
    int                       built_limit = 0;
    logic [SIEVE_BOUND_W-1:0] bound_reg = SIEVE_BOUND_W'(SIEVE_BOUND_RESET);

    mobius_table_sieve_top DUT (.*);

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void build_mobius_table(input int bnd);
        int n;
        int p;
        int k;
        for (n = 0; n <= DEPTH; n++)
            sieve_marks[n] = 1'b0;
        for (n = 1; n <= bnd; n++)
            mu_mirror[n] = 2'sd1;
        for (p = 2; p <= bnd; p++) begin
            if (!sieve_marks[p]) begin
                for (n = p; n <= bnd; n += p) begin
                    sieve_marks[n] = 1'b1;
                    mu_mirror[n] = -mu_mirror[n];
                end
                for (k = p * p; k <= bnd; k += p * p)
                    mu_mirror[k] = 2'sd0;
            end
        end
    endfunction

    function automatic mu_word_t predict_word(input logic f,
                                              input logic [SIEVE_BOUND_W-1:0] idx);
        mu_word_t w;
        int bnd;
        w.st = STATUS_ERR;
        w.mu = 2'sd0;
        if (f == FUNC_BUILD) begin
            bnd = (int'(bound_reg) > DEPTH) ? DEPTH : int'(bound_reg);
            build_mobius_table(bnd);
            built_limit = bnd;
            table_ready = 1'b1;
            w.st = STATUS_DONE;
        end
        else if (table_ready && idx != 0 && int'(idx) <= built_limit) begin
            w.st = STATUS_OK;
            w.mu = mu_mirror[idx];
        end
        return w;
    endfunction

    always @(negedge clk) begin
        sieve_cmd_t next_cmd;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (!start || word_taken) begin
            if (cmd_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_cmd = cmd_q.pop_front();
                start <= 1'b1;
                func <= next_cmd.f;
                query_index <= next_cmd.idx;
            end
            else begin
                start <= 1'b0;
                func <= 1'($urandom_range(0, 1));
                query_index <= SIEVE_BOUND_W'($urandom_range(0, 2047));
            end
        end
    end

    always @(posedge clk) begin
        mu_word_t want;
        if (!rst_n) begin
            word_taken <= 1'b0;
        end
        else begin
            word_taken <= start && !busy;
            if (result_strobe) begin
                if (awaited_words.size() == 0) begin
                    $display("%0t: unexpected word, status %0d value %0d",
                             $time, status, mobius_value);
                    fault_count++;
                end
                else begin
                    want = awaited_words.pop_front();
                    if (status !== want.st) begin
                        $display("%0t: status expected %0d got %0d", $time, want.st, status);
                        fault_count++;
                    end
                    if (mobius_value !== want.mu) begin
                        $display("%0t: mobius_value expected %0d got %0d",
                                 $time, want.mu, mobius_value);
                        fault_count++;
                    end
                end
            end
            if (start && !busy)
                awaited_words.push_back(predict_word(func, query_index));
        end
    end

    task automatic queue_word(input logic f, input logic [SIEVE_BOUND_W-1:0] idx);
        sieve_cmd_t c;
        c.f = f;
        c.idx = idx;
        cmd_q.push_back(c);
        items_sent++;
    endtask

    task automatic apb_write_bound(input logic [SIEVE_BOUND_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * CFG_IDX_SIEVE_BOUND);
        pwdata <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        bound_reg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (cmd_q.size() != 0 || start || busy || awaited_words.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [SIEVE_BOUND_W-1:0] pick_index(input int bnd);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return SIEVE_BOUND_W'($urandom_range(bnd + 1, 2047));
        if (r == 2 || bnd == 0)
            return SIEVE_BOUND_W'($urandom_range(0, 2047));
        return SIEVE_BOUND_W'($urandom_range(1, bnd));
    endfunction

    initial begin
        int plan_bound;
        int lookups;
        logic [SIEVE_BOUND_W-1:0] new_bound;
        int dir_idx [10];

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_word(FUNC_LOOKUP, 11'd1);
        queue_word(FUNC_LOOKUP, 11'd0);
        queue_word(FUNC_LOOKUP, 11'd1024);
        queue_word(FUNC_BUILD, 11'd0);
        dir_idx = '{1, 2, 4, 6, 30, 1021, 1023, 1024, 0, 2047};
        foreach (dir_idx[i])
            queue_word(FUNC_LOOKUP, SIEVE_BOUND_W'(dir_idx[i]));
        wait_drained();
        apb_write_bound(11'd0);
        queue_word(FUNC_LOOKUP, 11'd1000);
        queue_word(FUNC_BUILD, 11'd2047);
        queue_word(FUNC_LOOKUP, 11'd1);
        wait_drained();
        apb_write_bound(11'd2047);
        queue_word(FUNC_BUILD, 11'd0);
        queue_word(FUNC_LOOKUP, 11'd1024);
        queue_word(FUNC_LOOKUP, 11'd1023);
        wait_drained();
        apb_write_bound(11'd1);
        queue_word(FUNC_BUILD, 11'd1);
        queue_word(FUNC_LOOKUP, 11'd1);
        queue_word(FUNC_LOOKUP, 11'd2);
        wait_drained();

        plan_bound = 1;
        items_sent = 0;
        while (items_sent < RANDOM_WORDS) begin
            sender_idle_pct = (items_sent < RANDOM_WORDS / 3) ? 22 :
                              (items_sent < 2 * RANDOM_WORDS / 3) ? 61 : 0;
            case ($urandom_range(0, 15))
                0:       new_bound = SIEVE_BOUND_W'($urandom_range(1000, 2047));
                1:       new_bound = SIEVE_BOUND_W'($urandom_range(0, 3));
                2, 3:    new_bound = SIEVE_BOUND_W'($urandom_range(81, 300));
                default: new_bound = SIEVE_BOUND_W'($urandom_range(1, 80));
            endcase
            apb_write_bound(new_bound);
            repeat ($urandom_range(0, 4))
                queue_word(FUNC_LOOKUP, pick_index(plan_bound));
            plan_bound = (int'(new_bound) > DEPTH) ? DEPTH : int'(new_bound);
            queue_word(FUNC_BUILD, SIEVE_BOUND_W'($urandom_range(0, 2047)));
            lookups = $urandom_range(20, 60);
            repeat (lookups) begin
                if ($urandom_range(0, 39) == 0)
                    queue_word(FUNC_BUILD, SIEVE_BOUND_W'($urandom_range(0, 2047)));
                else
                    queue_word(FUNC_LOOKUP, pick_index(plan_bound));
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
